@@ src/rectangle_endpoint_rank_sorter_unit_assert.svh @@
// Assertion macros for the rectangle endpoint rank sorter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RECTANGLE_ENDPOINT_RANK_SORTER_UNIT_ASSERT_SVH
`define RECTANGLE_ENDPOINT_RANK_SORTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RESU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RESU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RESU_ASSERT_IMPL(lbl, ante, cons, msg)
`define RESU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/resu_pkg.sv @@
// Shared types, codes and the endpoint ordering function of the rank sorter.
// No dependencies.
package resu_pkg;

    localparam int COORD_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_BOUNDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_XL_CLOSED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_XR_CLOSED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_YL_CLOSED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_YH_CLOSED = 3'd4;

    localparam logic [1:0] KIND_RIGHT_OPEN = 2'd0;
    localparam logic [1:0] KIND_LEFT_CLOSED = 2'd1;
    localparam logic [1:0] KIND_RIGHT_CLOSED = 2'd2;
    localparam logic [1:0] KIND_LEFT_OPEN = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] value;
        logic               closed;
    } end_t;

    typedef struct packed {
        end_t x_lo;
        end_t x_hi;
        end_t y_lo;
        end_t y_hi;
    } row_t;

    function automatic logic [1:0] kind_of(logic is_left, logic closed);
        logic [1:0] k;
        if (is_left)
        begin
            k = closed ? KIND_LEFT_CLOSED : KIND_LEFT_OPEN;
        end
        else
        begin
            k = closed ? KIND_RIGHT_CLOSED : KIND_RIGHT_OPEN;
        end
        return k;
    endfunction

    // True if endpoint a comes before endpoint b on the same axis.
    function automatic logic precedes(end_t a, logic a_left, end_t b, logic b_left,
                                      logic a_idx_lt);
        logic [1:0] ka;
        logic [1:0] kb;
        logic       r;
        ka = kind_of(a_left, a.closed);
        kb = kind_of(b_left, b.closed);
        if (a.value != b.value)
        begin
            r = $signed(a.value) < $signed(b.value);
        end
        else if (ka != kb)
        begin
            r = ka < kb;
        end
        else
        begin
            r = a_idx_lt;
        end
        return r;
    endfunction

endpackage

@@ src/resu_end_store.sv @@
// Endpoint store: one row per rectangle with both x and both y ends.
// Depends on resu_pkg for the row type.
module resu_end_store #(
    parameter int ROWS = 16,
    parameter int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                clk,
    input  logic                we,
    input  logic [RW-1:0]       waddr,
    input  resu_pkg::row_t      wdata,
    input  logic [RW-1:0]       raddr,
    output resu_pkg::row_t      rdata
);

    resu_pkg::row_t mem [ROWS];
    resu_pkg::row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/resu_rank_store.sv @@
// Rank store: ranks per endpoint, kept per rectangle, and the endpoint at each
// sorted position for both axes. No package dependencies.
module resu_rank_store #(
    parameter int RECTS = 16,
    parameter int EW = $clog2(2 * RECTS),
    parameter int RW = (RECTS > 1) ? $clog2(RECTS) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [EW-1:0] wend,
    input  logic [EW-1:0] rank_x,
    input  logic [EW-1:0] rank_y,
    input  logic [EW-1:0] rd_pos,
    input  logic [RW-1:0] rd_rect,
    output logic [EW-1:0] at_x,
    output logic [EW-1:0] at_y,
    output logic [EW-1:0] rank_x_lo,
    output logic [EW-1:0] rank_x_hi,
    output logic [EW-1:0] rank_y_lo,
    output logic [EW-1:0] rank_y_hi
);

    localparam int ENDS = 2 * RECTS;

    logic [2*EW-1:0] rank_lo_mem [RECTS];
    logic [2*EW-1:0] rank_hi_mem [RECTS];
    logic [EW-1:0]   at_x_mem [ENDS];
    logic [EW-1:0]   at_y_mem [ENDS];

    logic [2*EW-1:0] lo_reg;
    logic [2*EW-1:0] hi_reg;
    logic [EW-1:0]   at_x_reg;
    logic [EW-1:0]   at_y_reg;
    logic [RW-1:0]   wrow;

    assign wrow = RW'(wend >> 1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (wend[0])
            begin
                rank_hi_mem[wrow] <= {rank_x, rank_y};
            end
            else
            begin
                rank_lo_mem[wrow] <= {rank_x, rank_y};
            end
            at_x_mem[rank_x] <= wend;
            at_y_mem[rank_y] <= wend;
        end
        lo_reg <= rank_lo_mem[rd_rect];
        hi_reg <= rank_hi_mem[rd_rect];
        at_x_reg <= at_x_mem[rd_pos];
        at_y_reg <= at_y_mem[rd_pos];
    end

    assign at_x = at_x_reg;
    assign at_y = at_y_reg;
    assign rank_x_lo = lo_reg[2*EW-1:EW];
    assign rank_y_lo = lo_reg[EW-1:0];
    assign rank_x_hi = hi_reg[2*EW-1:EW];
    assign rank_y_hi = hi_reg[EW-1:0];

endmodule

@@ src/rectangle_endpoint_rank_sorter_unit.sv @@
// Rectangle endpoint rank sorter, top level. Rectangles are accepted in the load state.
// After the last one, each of the 2n endpoints is ranked by one scan of the endpoint
// store, both axes in lockstep.
// Then each of the 2n results is read, loaded into the output registers and held until taken.
// Reset clears control state and the shared-bounds flag and sets the shared closed
// flags; the stores need no clearing and hold nothing defined until loaded.
module rectangle_endpoint_rank_sorter_unit #(
    parameter int MAX_RECTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] x_left,
    input  logic [31:0] x_right,
    input  logic [31:0] y_low,
    input  logic [31:0] y_high,
    input  logic        x_left_closed,
    input  logic        x_right_closed,
    input  logic        y_low_closed,
    input  logic        y_high_closed,
    input  logic        last_rect,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  position,
    output logic [3:0]  x_owner,
    output logic [3:0]  y_owner,
    output logic        x_owner_is_left,
    output logic        rect_valid,
    output logic [4:0]  rank_x_left,
    output logic [4:0]  rank_x_right,
    output logic [4:0]  rank_y_low,
    output logic [4:0]  rank_y_high,
    output logic        last_result,
    input  logic        cfg_we,
    input  logic [resu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        cfg_data
);

    `include "rectangle_endpoint_rank_sorter_unit_assert.svh"

    localparam int EW = $clog2(2 * MAX_RECTS);
    localparam int CW = $clog2(2 * MAX_RECTS + 1);
    localparam int NW = $clog2(MAX_RECTS + 1);
    localparam int RW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PIV_RD = 3'd1;
    localparam logic [2:0] S_PIV_LAT = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT_RD = 3'd4;
    localparam logic [2:0] S_OUT_LD = 3'd5;
    localparam logic [2:0] S_OUT_WAIT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] count_reg, count_next;
    logic [CW-1:0] ends_reg, ends_next;
    logic [CW-1:0] e_reg, e_next;
    logic [CW-1:0] f_reg, f_next;
    logic [CW-1:0] k_reg, k_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [EW-1:0] pend_f_reg, pend_f_next;
    logic [EW-1:0] cnt_x_reg, cnt_x_next;
    logic [EW-1:0] cnt_y_reg, cnt_y_next;
    logic          out_valid_reg, out_valid_next;
    logic          sh_bounds_reg, sh_bounds_next;
    logic          sh_xl_reg, sh_xl_next;
    logic          sh_xr_reg, sh_xr_next;
    logic          sh_yl_reg, sh_yl_next;
    logic          sh_yh_reg, sh_yh_next;

    resu_pkg::end_t piv_x_reg, piv_x_next;
    resu_pkg::end_t piv_y_reg, piv_y_next;

    logic [4:0] position_reg;
    logic [3:0] x_owner_reg;
    logic [3:0] y_owner_reg;
    logic       x_left_reg;
    logic       rect_valid_reg;
    logic [4:0] rxl_reg;
    logic [4:0] rxr_reg;
    logic [4:0] ryl_reg;
    logic [4:0] ryh_reg;
    logic       last_reg;

    logic           in_fire;
    logic           out_fire;
    logic           store_we;
    resu_pkg::row_t store_wdata;
    logic [RW-1:0]  store_raddr;
    resu_pkg::row_t store_rdata;
    resu_pkg::end_t cand_x;
    resu_pkg::end_t cand_y;
    logic [EW-1:0]  e_ix;
    logic           idx_lt;
    logic           inc_x;
    logic           inc_y;
    logic [EW-1:0]  cnt_x_fin;
    logic [EW-1:0]  cnt_y_fin;
    logic           scan_done;
    logic           rank_we;
    logic [EW-1:0]  at_x;
    logic [EW-1:0]  at_y;
    logic [EW-1:0]  rk_x_lo;
    logic [EW-1:0]  rk_x_hi;
    logic [EW-1:0]  rk_y_lo;
    logic [EW-1:0]  rk_y_hi;
    logic           k_valid;

    assign in_stall = (state_reg != S_LOAD);
    assign in_fire = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign store_we = in_fire && (count_reg < NW'(MAX_RECTS));

    always_comb
    begin
        store_wdata.x_lo.value = x_left;
        store_wdata.x_hi.value = x_right;
        store_wdata.y_lo.value = y_low;
        store_wdata.y_hi.value = y_high;
        store_wdata.x_lo.closed = sh_bounds_reg ? sh_xl_reg : x_left_closed;
        store_wdata.x_hi.closed = sh_bounds_reg ? sh_xr_reg : x_right_closed;
        store_wdata.y_lo.closed = sh_bounds_reg ? sh_yl_reg : y_low_closed;
        store_wdata.y_hi.closed = sh_bounds_reg ? sh_yh_reg : y_high_closed;
    end

    assign e_ix = e_reg[EW-1:0];
    assign store_raddr = (state_reg == S_PIV_RD) ? RW'(e_ix >> 1) : RW'(f_reg[EW-1:0] >> 1);

    resu_end_store #(
        .ROWS (MAX_RECTS),
        .RW   (RW)
    ) u_end_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (RW'(count_reg)),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    assign cand_x = pend_f_reg[0] ? store_rdata.x_hi : store_rdata.x_lo;
    assign cand_y = pend_f_reg[0] ? store_rdata.y_hi : store_rdata.y_lo;
    assign idx_lt = (pend_f_reg >> 1) < (e_ix >> 1);
    assign inc_x = pend_vld_reg && (pend_f_reg != e_ix) &&
                   resu_pkg::precedes(cand_x, !pend_f_reg[0], piv_x_reg, !e_ix[0], idx_lt);
    assign inc_y = pend_vld_reg && (pend_f_reg != e_ix) &&
                   resu_pkg::precedes(cand_y, !pend_f_reg[0], piv_y_reg, !e_ix[0], idx_lt);
    assign cnt_x_fin = cnt_x_reg + EW'(inc_x);
    assign cnt_y_fin = cnt_y_reg + EW'(inc_y);
    assign scan_done = pend_vld_reg && (CW'(pend_f_reg) == ends_reg - CW'(1));
    assign rank_we = (state_reg == S_SCAN) && scan_done;

    resu_rank_store #(
        .RECTS (MAX_RECTS),
        .EW    (EW),
        .RW    (RW)
    ) u_rank_store (
        .clk       (clk),
        .we        (rank_we),
        .wend      (e_ix),
        .rank_x    (cnt_x_fin),
        .rank_y    (cnt_y_fin),
        .rd_pos    (k_reg[EW-1:0]),
        .rd_rect   (RW'(k_reg)),
        .at_x      (at_x),
        .at_y      (at_y),
        .rank_x_lo (rk_x_lo),
        .rank_x_hi (rk_x_hi),
        .rank_y_lo (rk_y_lo),
        .rank_y_hi (rk_y_hi)
    );

    assign k_valid = k_reg < CW'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ends_next = ends_reg;
        e_next = e_reg;
        f_next = f_reg;
        k_next = k_reg;
        pend_vld_next = pend_vld_reg;
        pend_f_next = pend_f_reg;
        cnt_x_next = cnt_x_reg;
        cnt_y_next = cnt_y_reg;
        out_valid_next = out_valid_reg;
        piv_x_next = piv_x_reg;
        piv_y_next = piv_y_reg;
        sh_bounds_next = sh_bounds_reg;
        sh_xl_next = sh_xl_reg;
        sh_xr_next = sh_xr_reg;
        sh_yl_next = sh_yl_reg;
        sh_yh_next = sh_yh_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                resu_pkg::CFG_SHARED_BOUNDS:    sh_bounds_next = cfg_data;
                resu_pkg::CFG_SHARED_XL_CLOSED: sh_xl_next = cfg_data;
                resu_pkg::CFG_SHARED_XR_CLOSED: sh_xr_next = cfg_data;
                resu_pkg::CFG_SHARED_YL_CLOSED: sh_yl_next = cfg_data;
                resu_pkg::CFG_SHARED_YH_CLOSED: sh_yh_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (store_we)
                    begin
                        count_next = count_reg + NW'(1);
                    end
                    if (last_rect)
                    begin
                        ends_next = CW'({count_next, 1'b0});
                        e_next = '0;
                        state_next = S_PIV_RD;
                    end
                end
            end
            S_PIV_RD:
            begin
                f_next = '0;
                state_next = S_PIV_LAT;
            end
            S_PIV_LAT:
            begin
                piv_x_next = e_ix[0] ? store_rdata.x_hi : store_rdata.x_lo;
                piv_y_next = e_ix[0] ? store_rdata.y_hi : store_rdata.y_lo;
                pend_vld_next = 1'b1;
                pend_f_next = '0;
                f_next = CW'(1);
                cnt_x_next = '0;
                cnt_y_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (f_reg < ends_reg)
                begin
                    pend_vld_next = 1'b1;
                    pend_f_next = f_reg[EW-1:0];
                    f_next = f_reg + CW'(1);
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
                cnt_x_next = cnt_x_fin;
                cnt_y_next = cnt_y_fin;
                if (scan_done)
                begin
                    pend_vld_next = 1'b0;
                    e_next = e_reg + CW'(1);
                    k_next = '0;
                    state_next = (e_reg + CW'(1) == ends_reg) ? S_OUT_RD : S_PIV_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                out_valid_next = 1'b1;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next = k_reg + CW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ends_reg <= '0;
            e_reg <= '0;
            f_reg <= '0;
            k_reg <= '0;
            pend_vld_reg <= 1'b0;
            pend_f_reg <= '0;
            cnt_x_reg <= '0;
            cnt_y_reg <= '0;
            out_valid_reg <= 1'b0;
            sh_bounds_reg <= 1'b0;
            sh_xl_reg <= 1'b1;
            sh_xr_reg <= 1'b1;
            sh_yl_reg <= 1'b1;
            sh_yh_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ends_reg <= ends_next;
            e_reg <= e_next;
            f_reg <= f_next;
            k_reg <= k_next;
            pend_vld_reg <= pend_vld_next;
            pend_f_reg <= pend_f_next;
            cnt_x_reg <= cnt_x_next;
            cnt_y_reg <= cnt_y_next;
            out_valid_reg <= out_valid_next;
            sh_bounds_reg <= sh_bounds_next;
            sh_xl_reg <= sh_xl_next;
            sh_xr_reg <= sh_xr_next;
            sh_yl_reg <= sh_yl_next;
            sh_yh_reg <= sh_yh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_x_reg <= piv_x_next;
        piv_y_reg <= piv_y_next;
        if (state_reg == S_OUT_LD)
        begin
            position_reg <= 5'(k_reg);
            x_owner_reg <= 4'(at_x >> 1);
            y_owner_reg <= 4'(at_y >> 1);
            x_left_reg <= !at_x[0];
            rect_valid_reg <= k_valid;
            rxl_reg <= k_valid ? 5'(rk_x_lo) : 5'd0;
            rxr_reg <= k_valid ? 5'(rk_x_hi) : 5'd0;
            ryl_reg <= k_valid ? 5'(rk_y_lo) : 5'd0;
            ryh_reg <= k_valid ? 5'(rk_y_hi) : 5'd0;
            last_reg <= (k_reg + CW'(1) == ends_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign position = position_reg;
    assign x_owner = x_owner_reg;
    assign y_owner = y_owner_reg;
    assign x_owner_is_left = x_left_reg;
    assign rect_valid = rect_valid_reg;
    assign rank_x_left = rxl_reg;
    assign rank_x_right = rxr_reg;
    assign rank_y_low = ryl_reg;
    assign rank_y_high = ryh_reg;
    assign last_result = last_reg;

    `RESU_ASSERT_IMPL(a_rank_in_range, rank_we, (CW'(cnt_x_fin) < ends_reg) && (CW'(cnt_y_fin) < ends_reg), "rank beyond endpoint count")
    `RESU_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= NW'(MAX_RECTS), "rectangle count beyond capacity")
    `RESU_ASSERT_NEXT(a_next_word, out_fire && !last_reg, (k_reg == $past(k_reg) + CW'(1)) && (state_reg == S_OUT_RD), "result position did not advance")
    `RESU_ASSERT_NEXT(a_run_end, out_fire && last_reg, (count_reg == '0) && (state_reg == S_LOAD), "set not restarted after final word")
    `RESU_ASSERT_IMPL(a_no_load_in_output, in_fire, !out_valid_reg, "input word taken while a result is pending")

endmodule

@@ tb/rectangle_endpoint_rank_sorter_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the rectangle endpoint rank sorter top level.
// Depends on resu_pkg and rectangle_endpoint_rank_sorter_unit; it predicts the
// sorted endpoint words of each rectangle set and checks every output word.
module rectangle_endpoint_rank_sorter_unit_tb;

    localparam int MAX_RECTS = 16;
    localparam int NUM_ENDS = 2 * MAX_RECTS;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 170;

    typedef struct packed {
        logic [31:0] xl;
        logic [31:0] xr;
        logic [31:0] yl;
        logic [31:0] yh;
        logic        xlc;
        logic        xrc;
        logic        ylc;
        logic        yhc;
        logic        last;
    } rect_item_t;

    typedef struct packed {
        logic [4:0] position;
        logic [3:0] x_owner;
        logic [3:0] y_owner;
        logic       x_left;
        logic       rect_valid;
        logic [4:0] rank_xl;
        logic [4:0] rank_xr;
        logic [4:0] rank_yl;
        logic [4:0] rank_yh;
        logic       last;
    } rank_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] x_left;
    logic [31:0] x_right;
    logic [31:0] y_low;
    logic [31:0] y_high;
    logic        x_left_closed;
    logic        x_right_closed;
    logic        y_low_closed;
    logic        y_high_closed;
    logic        last_rect;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  position;
    logic [3:0]  x_owner;
    logic [3:0]  y_owner;
    logic        x_owner_is_left;
    logic        rect_valid;
    logic [4:0]  rank_x_left;
    logic [4:0]  rank_x_right;
    logic [4:0]  rank_y_low;
    logic [4:0]  rank_y_high;
    logic        last_result;
    logic        cfg_we;
    logic [resu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic        cfg_data;

    rank_word_t  position_words_due[$];
    rank_word_t  want_word;
    logic [37:0] x_keys[NUM_ENDS];
    logic [37:0] y_keys[NUM_ENDS];
    int          rects_loaded;
    int          items_sent;
    int          mismatches;
    int          hold_cycles;
    logic        calm;
    logic        shared_mode;
    logic        shared_xl;
    logic        shared_xr;
    logic        shared_yl;
    logic        shared_yh;

    rectangle_endpoint_rank_sorter_unit #(
        .MAX_RECTS(MAX_RECTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .x_left(x_left),
        .x_right(x_right),
        .y_low(y_low),
        .y_high(y_high),
        .x_left_closed(x_left_closed),
        .x_right_closed(x_right_closed),
        .y_low_closed(y_low_closed),
        .y_high_closed(y_high_closed),
        .last_rect(last_rect),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .position(position),
        .x_owner(x_owner),
        .y_owner(y_owner),
        .x_owner_is_left(x_owner_is_left),
        .rect_valid(rect_valid),
        .rank_x_left(rank_x_left),
        .rank_x_right(rank_x_right),
        .rank_y_low(rank_y_low),
        .rank_y_high(rank_y_high),
        .last_result(last_result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
        begin
            report_mismatch(name, got, want);
        end
    endtask

    // Ordering key: offset-binary value, then endpoint kind, then rectangle index.
    function automatic logic [37:0] order_key(logic [31:0] value, logic is_left,
                                              logic closed, int rect);
        logic [1:0] kind;
        logic [3:0] idx;
        idx = rect[3:0];
        if (is_left)
        begin
            kind = closed ? resu_pkg::KIND_LEFT_CLOSED : resu_pkg::KIND_LEFT_OPEN;
        end
        else
        begin
            kind = closed ? resu_pkg::KIND_RIGHT_CLOSED : resu_pkg::KIND_RIGHT_OPEN;
        end
        return {value ^ 32'h8000_0000, kind, idx};
    endfunction

    task automatic rank_endpoints_on_load(rect_item_t r);
        logic       xlc;
        logic       xrc;
        logic       ylc;
        logic       yhc;
        int         slot;
        int         n;
        int         ends;
        int         rx;
        int         ry;
        int         x_rank[NUM_ENDS];
        int         y_rank[NUM_ENDS];
        int         x_at[NUM_ENDS];
        int         y_at[NUM_ENDS];
        rank_word_t w;
        if (rects_loaded < MAX_RECTS)
        begin
            slot = rects_loaded;
            xlc = shared_mode ? shared_xl : r.xlc;
            xrc = shared_mode ? shared_xr : r.xrc;
            ylc = shared_mode ? shared_yl : r.ylc;
            yhc = shared_mode ? shared_yh : r.yhc;
            x_keys[2 * slot] = order_key(r.xl, 1'b1, xlc, slot);
            x_keys[2 * slot + 1] = order_key(r.xr, 1'b0, xrc, slot);
            y_keys[2 * slot] = order_key(r.yl, 1'b1, ylc, slot);
            y_keys[2 * slot + 1] = order_key(r.yh, 1'b0, yhc, slot);
            rects_loaded++;
        end
        if (r.last)
        begin
            n = rects_loaded;
            ends = 2 * n;
            for (int e = 0; e < ends; e++)
            begin
                rx = 0;
                ry = 0;
                for (int f = 0; f < ends; f++)
                begin
                    if (x_keys[f] < x_keys[e])
                    begin
                        rx++;
                    end
                    if (y_keys[f] < y_keys[e])
                    begin
                        ry++;
                    end
                end
                x_rank[e] = rx;
                y_rank[e] = ry;
                x_at[rx] = e;
                y_at[ry] = e;
            end
            for (int k = 0; k < ends; k++)
            begin
                w = '0;
                w.position = k[4:0];
                w.x_owner = 4'(x_at[k] / 2);
                w.y_owner = 4'(y_at[k] / 2);
                w.x_left = (x_at[k] % 2) == 0;
                w.rect_valid = k < n;
                if (k < n)
                begin
                    w.rank_xl = 5'(x_rank[2 * k]);
                    w.rank_xr = 5'(x_rank[2 * k + 1]);
                    w.rank_yl = 5'(y_rank[2 * k]);
                    w.rank_yh = 5'(y_rank[2 * k + 1]);
                end
                w.last = (k == ends - 1);
                position_words_due.push_back(w);
            end
            rects_loaded = 0;
        end
    endtask

    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            v = $urandom_range(0, 6);
            v = (v - 32'd3) << 16;
        end
        else if (pick < 85)
        begin
            v = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    function automatic rect_item_t random_rect(logic last);
        rect_item_t r;
        r.xl = random_coord();
        r.xr = random_coord();
        r.yl = random_coord();
        r.yh = random_coord();
        r.xlc = 1'($urandom_range(0, 1));
        r.xrc = 1'($urandom_range(0, 1));
        r.ylc = 1'($urandom_range(0, 1));
        r.yhc = 1'($urandom_range(0, 1));
        r.last = last;
        return r;
    endfunction

    task automatic send_rect(rect_item_t r);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_left <= r.xl;
        x_right <= r.xr;
        y_low <= r.yl;
        y_high <= r.yh;
        x_left_closed <= r.xlc;
        x_right_closed <= r.xrc;
        y_low_closed <= r.ylc;
        y_high_closed <= r.yhc;
        last_rect <= r.last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        rank_endpoints_on_load(r);
        items_sent++;
    endtask

    task automatic send_random_set(int count);
        for (int i = 0; i < count; i++)
        begin
            send_rect(random_rect(i == count - 1));
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (position_words_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [resu_pkg::CFG_IDX_W-1:0] index, logic data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        case (index)
            resu_pkg::CFG_SHARED_BOUNDS: shared_mode = data;
            resu_pkg::CFG_SHARED_XL_CLOSED: shared_xl = data;
            resu_pkg::CFG_SHARED_XR_CLOSED: shared_xr = data;
            resu_pkg::CFG_SHARED_YL_CLOSED: shared_yl = data;
            resu_pkg::CFG_SHARED_YH_CLOSED: shared_yh = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_shared_flags(logic xl, logic xr, logic yl, logic yh);
        write_reg(resu_pkg::CFG_SHARED_XL_CLOSED, xl);
        write_reg(resu_pkg::CFG_SHARED_XR_CLOSED, xr);
        write_reg(resu_pkg::CFG_SHARED_YL_CLOSED, yl);
        write_reg(resu_pkg::CFG_SHARED_YH_CLOSED, yh);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (position_words_due.size() == 0)
            begin
                report_mismatch("word with none expected, position", position, 0);
            end
            else
            begin
                want_word = position_words_due.pop_front();
                check_field("position", position, want_word.position);
                check_field("x_owner", x_owner, want_word.x_owner);
                check_field("y_owner", y_owner, want_word.y_owner);
                check_field("x_owner_is_left", x_owner_is_left, want_word.x_left);
                check_field("rect_valid", rect_valid, want_word.rect_valid);
                check_field("rank_x_left", rank_x_left, want_word.rank_xl);
                check_field("rank_x_right", rank_x_right, want_word.rank_xr);
                check_field("rank_y_low", rank_y_low, want_word.rank_yl);
                check_field("rank_y_high", rank_y_high, want_word.rank_yh);
                check_field("last_result", last_result, want_word.last);
            end
        end
    end

    task automatic test_extreme_single_rects();
        rect_item_t r;
        r = random_rect(1'b1);
        r.xl = 32'h8000_0000;
        r.xr = 32'h7FFF_FFFF;
        r.yl = 32'h7FFF_FFFF;
        r.yh = 32'h8000_0000;
        {r.xlc, r.xrc, r.ylc, r.yhc} = 4'b0000;
        send_rect(r);
        r.xl = 32'hFFFF_FFFF;
        r.xr = 32'h0000_0000;
        r.yl = 32'h0000_0000;
        r.yh = 32'hFFFF_FFFF;
        {r.xlc, r.xrc, r.ylc, r.yhc} = 4'b1111;
        send_rect(r);
    endtask

    task automatic test_tie_order();
        rect_item_t r;
        r = random_rect(1'b0);
        r.xl = 32'h0;
        r.xr = 32'h0;
        r.yl = 32'h0001_0000;
        r.yh = 32'h0001_0000;
        {r.xlc, r.xrc, r.ylc, r.yhc} = 4'b1011;
        send_rect(r);
        {r.xlc, r.xrc, r.ylc, r.yhc} = 4'b0100;
        send_rect(r);
        {r.xlc, r.xrc, r.ylc, r.yhc} = 4'b1010;
        r.last = 1'b1;
        send_rect(r);
    endtask

    // The flags in force at load time are stored, so they change after the first
    // rectangle of the second set; its last two words arrive with the store full.
    task automatic test_shared_flags_and_full_store();
        wait_drained();
        write_reg(resu_pkg::CFG_SHARED_BOUNDS, 1'b1);
        write_shared_flags(1'b0, 1'b0, 1'b0, 1'b0);
        send_random_set(MAX_RECTS / 2 - 1);
        send_rect(random_rect(1'b0));
        wait_drained();
        write_shared_flags(1'b1, 1'b1, 1'b1, 1'b1);
        for (int i = resu_pkg::CFG_SHARED_YH_CLOSED + 1; i < (1 << resu_pkg::CFG_IDX_W); i++)
        begin
            write_reg(i[resu_pkg::CFG_IDX_W-1:0], 1'b0);
        end
        for (int i = 0; i < MAX_RECTS; i++)
        begin
            send_rect(random_rect(1'b0));
        end
        send_rect(random_rect(1'b1));
        wait_drained();
        write_reg(resu_pkg::CFG_SHARED_BOUNDS, 1'b0);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        @(posedge clk);
        hold_cycles = 400;
        send_random_set(4);
        send_random_set(4);
    endtask

    task automatic test_random_sets();
        int start;
        int set_size;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            calm = (items_sent - start) < 40;
            if ($urandom_range(0, 99) < 30)
            begin
                wait_drained();
                write_reg(resu_pkg::CFG_SHARED_BOUNDS, 1'($urandom_range(0, 1)));
                write_shared_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                set_size = $urandom_range(MAX_RECTS, MAX_RECTS + 2);
            end
            else
            begin
                set_size = $urandom_range(1, 6);
            end
            send_random_set(set_size);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_left = '0;
        x_right = '0;
        y_low = '0;
        y_high = '0;
        x_left_closed = 1'b0;
        x_right_closed = 1'b0;
        y_low_closed = 1'b0;
        y_high_closed = 1'b0;
        last_rect = 1'b0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = 1'b0;
        rects_loaded = 0;
        items_sent = 0;
        mismatches = 0;
        hold_cycles = 0;
        calm = 1'b0;
        shared_mode = 1'b0;
        shared_xl = 1'b1;
        shared_xr = 1'b1;
        shared_yl = 1'b1;
        shared_yh = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extreme_single_rects();
        test_tie_order();
        test_shared_flags_and_full_store();
        test_output_backpressure();
        test_random_sets();

        wait_drained();
        if (position_words_due.size() != 0)
        begin
            report_mismatch("words never received", position_words_due.size(), 0);
        end
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
